### design/olde_pkg.sv
package olde_pkg;

    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;

    localparam logic [OP_W-1:0] OP_APPEND       = 3'd0;
    localparam logic [OP_W-1:0] OP_TAKE_FRONT   = 3'd1;
    localparam logic [OP_W-1:0] OP_TAKE_BACK    = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE_VALUE = 3'd3;
    localparam logic [OP_W-1:0] OP_REMOVE_AT    = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_PAST_END  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

endpackage

### design/olde_ifs.sv
interface olde_req_if;
    logic                                valid;
    logic                                ready;
    logic [olde_pkg::OP_W-1:0]           operation;
    logic signed [olde_pkg::VALUE_W-1:0] value;
    logic [olde_pkg::POS_W-1:0]          position;

    modport source (output valid, output operation, output value, output position,
                    input ready);
    modport sink   (input valid, input operation, input value, input position,
                    output ready);
endinterface

interface olde_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [olde_pkg::STATUS_W-1:0]       status;
    logic signed [olde_pkg::VALUE_W-1:0] removed_value;
    logic [olde_pkg::COUNT_W-1:0]        entry_count;

    modport source (output valid, output status, output removed_value, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input removed_value, input entry_count,
                    output ready);
endinterface

### design/olde_ram.sv
module olde_ram #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32,
    parameter int AW         = 6
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic [AW-1:0]         rd_addr,
    output logic [DATA_WIDTH-1:0] rd_data
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

### design/ordered_list_delete_engine_unit.sv
// Ordered list engine: a bounded list of values kept front to back.
// Requests arrive on the req channel (operation, value, position) and each
// request yields exactly one word on the rsp channel (status, removed_value,
// entry_count). Words move when valid and ready are both high.
// The block handles one request at a time; req.ready is high only while the
// sequencer is idle. Entries live in a single-port-read, single-port-write
// memory, so all list work walks that memory one entry per cycle.
// Steps from acceptance to a valid result, with n entries held:
//   append, failed requests and unknown operations: straight to the final step;
//   removal at index i (front, back or position): fetch, then shift entries i+1 to n-1;
//   removal by value: scan from the front, then shift on a match; not found: scan to the end.
// Every path ends in the final step, which loads the output register.
// A new request can be taken in the first cycle its predecessor's result is
// valid, so a request is taken only once its predecessor has finished its steps.
// The result sits in an output register; a new request is accepted while it
// waits, and a stalled receiver only holds the sequencer at its final step
// until the register frees up. Reset clears the count, the sequencer state
// and the result valid flag; the memory needs no clearing pass, as only entries
// below the count are ever read into a result.
module ordered_list_delete_engine_unit #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    olde_req_if.sink   req,
    olde_rsp_if.source rsp
);

    import olde_pkg::*;

    localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = $clog2(DEPTH + 2);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [PW-1:0]         ptr_reg, ptr_next;
    logic [PW-1:0]         wp_reg, wp_next;
    logic [DATA_WIDTH-1:0] key_reg, key_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [DATA_WIDTH-1:0] removed_reg, removed_next;

    logic                  rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0]   rsp_status_reg, rsp_status_next;
    logic [VALUE_W-1:0]    rsp_removed_reg, rsp_removed_next;
    logic [COUNT_W-1:0]    rsp_count_reg, rsp_count_next;

    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [AW-1:0]         rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;

    logic [DATA_WIDTH+VALUE_W-1:0] key_wide;
    logic [DATA_WIDTH+VALUE_W-1:0] removed_wide;
    logic [CW+COUNT_W-1:0]         count_wide;
    logic [CW+POS_W-1:0]           pos_wide;
    logic [CW+POS_W-1:0]           cnt_cmp;
    logic [PW-1:0]                 count_p;
    logic [PW-1:0]                 wp_inc;
    logic [PW-1:0]                 take_idx;
    logic                          list_empty;
    logic                          list_full;
    logic                          pos_past_end;
    logic                          load_rsp;

    olde_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // The request value is compared and stored as its unsigned bit pattern.
    assign key_wide     = {{DATA_WIDTH{1'b0}}, req.value};
    assign removed_wide = {{VALUE_W{1'b0}}, removed_reg};
    assign count_wide   = {{COUNT_W{1'b0}}, count_reg};
    assign pos_wide     = {{CW{1'b0}}, req.position};
    assign cnt_cmp      = {{POS_W{1'b0}}, count_reg};
    assign count_p      = PW'(count_reg);
    assign wp_inc       = wp_reg + 1'b1;
    assign list_empty   = (count_reg == '0);
    assign list_full    = (count_reg == CW'(DEPTH));
    assign pos_past_end = (pos_wide >= cnt_cmp);
    assign load_rsp     = (state_reg == S_DONE) && (!rsp_valid_reg || rsp.ready);

    always_comb
    begin
        take_idx = '0;
        case (req.operation)
            OP_TAKE_BACK: take_idx = count_p - 1'b1;
            OP_REMOVE_AT: take_idx = pos_wide[PW-1:0];
            default:      take_idx = '0;
        endcase
    end

    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        ptr_next     = ptr_reg;
        wp_next      = wp_reg;
        key_next     = key_reg;
        status_next  = status_reg;
        removed_next = removed_reg;
        wr_en        = 1'b0;
        wr_addr      = wp_reg[AW-1:0];
        wr_data      = rd_data;
        rd_addr      = ptr_reg[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    key_next     = key_wide[DATA_WIDTH-1:0];
                    removed_next = '0;
                    status_next  = ST_DONE;
                    state_next   = S_DONE;
                    case (req.operation)
                        OP_APPEND:
                        begin
                            if (list_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = count_reg[AW-1:0];
                                wr_data    = key_wide[DATA_WIDTH-1:0];
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_TAKE_FRONT, OP_TAKE_BACK, OP_REMOVE_AT:
                        begin
                            if (list_empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else if ((req.operation == OP_REMOVE_AT) && pos_past_end)
                            begin
                                status_next = ST_PAST_END;
                            end
                            else
                            begin
                                rd_addr    = take_idx[AW-1:0];
                                wp_next    = take_idx;
                                ptr_next   = take_idx + 1'b1;
                                state_next = S_FETCH;
                            end
                        end
                        OP_REMOVE_VALUE:
                        begin
                            if (list_empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                rd_addr    = '0;
                                ptr_next   = PW'(1);
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            status_next = ST_DONE;
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                removed_next = rd_data;
                ptr_next     = ptr_reg + 1'b1;
                state_next   = S_SHIFT;
            end
            S_SCAN:
            begin
                // The read of the next entry is issued every cycle, so on a
                // match the first entry to move forward is already on its way.
                ptr_next = ptr_reg + 1'b1;
                if (rd_data == key_reg)
                begin
                    removed_next = rd_data;
                    wp_next      = ptr_reg - 1'b1;
                    state_next   = S_SHIFT;
                end
                else if (ptr_reg == count_p)
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_DONE;
                end
            end
            S_SHIFT:
            begin
                if (wp_inc < count_p)
                begin
                    wr_en    = 1'b1;
                    ptr_next = ptr_reg + 1'b1;
                    wp_next  = wp_inc;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (load_rsp)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next   = rsp_valid_reg;
        rsp_status_next  = rsp_status_reg;
        rsp_removed_next = rsp_removed_reg;
        rsp_count_next   = rsp_count_reg;
        if (load_rsp)
        begin
            rsp_valid_next   = 1'b1;
            rsp_status_next  = status_reg;
            rsp_removed_next = removed_wide[VALUE_W-1:0];
            rsp_count_next   = count_wide[COUNT_W-1:0];
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg         <= ptr_next;
        wp_reg          <= wp_next;
        key_reg         <= key_next;
        status_reg      <= status_next;
        removed_reg     <= removed_next;
        rsp_status_reg  <= rsp_status_next;
        rsp_removed_reg <= rsp_removed_next;
        rsp_count_reg   <= rsp_count_next;
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = rsp_status_reg;
    assign rsp.removed_value = rsp_removed_reg;
    assign rsp.entry_count   = rsp_count_reg;

endmodule

### design/olde_checker.sv
module olde_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                req_valid,
    input logic                                req_ready,
    input logic                                rsp_valid,
    input logic                                rsp_ready,
    input logic [olde_pkg::STATUS_W-1:0]       status,
    input logic signed [olde_pkg::VALUE_W-1:0] removed_value,
    input logic [olde_pkg::COUNT_W-1:0]        entry_count
);

    import olde_pkg::*;

    // A stalled result word holds still.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status)
            && $stable(removed_value) && $stable(entry_count))
    else $error("stalled result word changed");

    // Requests are worked one at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
    else $error("request accepted while another is in work");

    // A new result is always loaded at the end of a busy stretch.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !$past(req_ready))
    else $error("result appeared without a request in work");

    // Only a successful removal reports a value.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != ST_DONE) |-> (removed_value == '0))
    else $error("failed request reported a removed value");

    // A failed request leaves the count where it was reported last.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready |=> !rsp_valid || (status == ST_DONE)
            || (entry_count == $past(entry_count)))
    else $error("failed request changed the count");

endmodule

bind ordered_list_delete_engine_unit olde_checker u_olde_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .status        (rsp.status),
    .removed_value (rsp.removed_value),
    .entry_count   (rsp.entry_count)
);
